### hdl/assert_macros.svh
// Assertion macros for the RTL modules of the rule-set unranker; the datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/rrsu_pkg.sv
// Shared constants, command/status types and a helper function of the rule-set unranker.
`default_nettype none
package rrsu_pkg;
    localparam int MAX_RULES   = 16;
    localparam int MAX_LETTERS = 16;
    localparam int MAX_STR_LEN = 4;

    localparam int RANK_W     = 64;
    localparam int SHAPE_W    = 33;
    localparam int PATS_W     = 17;
    localparam int WORD_W     = 16;
    localparam int SLOT_W     = 4;
    localparam int LEN_W      = 3;
    localparam int ALPHA_W    = 5;
    localparam int RULES_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int DIGIT_W    = 4;
    localparam int DIV_CNT_W  = 6;
    localparam int DIG_BITS   = 8;
    localparam int DIG_STEPS  = 5;
    localparam int DIG_Q_W    = DIG_BITS * DIG_STEPS;
    localparam int DSUB_W     = 3;
    localparam int DCNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REP  = 2'd3;

    typedef struct packed {
        logic load_item;
        logic cnt_block;
        logic cnt_term;
        logic div_init;
        logic div_step;
        logic dec_init;
        logic dec_block;
        logic dec_term;
        logic dig_init_sub;
        logic dig_init_term;
        logic dig_step;
        logic emit_ok;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic rl_last;
        logic pl_last;
        logic div_last;
        logic s_lt_block;
        logic s_lt_pats;
        logic dig_none;
        logic slot_last;
        logic out_free;
    } t_status;

    // Bits per packed letter: ceil(log2(alphabet)) for alphabets of 2 to 16.
    function automatic logic [LEN_W-1:0] letter_bits(input logic [ALPHA_W-1:0] a);
        logic [LEN_W-1:0] b;
        if (a <= 5'd2)      b = 3'd1;
        else if (a <= 5'd4) b = 3'd2;
        else if (a <= 5'd8) b = 3'd3;
        else                b = 3'd4;
        return b;
    endfunction
endpackage
`default_nettype wire

### hdl/rrsu_ctrl.sv
// Sequencer of the rule-set unranker: counts shapes, divides, decodes, emits.
`default_nettype none
module rrsu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire rrsu_pkg::t_status i_sts,
    output rrsu_pkg::t_cmd        o_cmd
);
    import rrsu_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ERR      = 4'd1;
    localparam logic [3:0] S_CNT_BLK  = 4'd2;
    localparam logic [3:0] S_CNT_TRM  = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_DEC_INIT = 4'd5;
    localparam logic [3:0] S_DEC_BLK  = 4'd6;
    localparam logic [3:0] S_DEC_TRM  = 4'd7;
    localparam logic [3:0] S_DIG      = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_sts.bad ? S_ERR : S_CNT_BLK;
                end
            end
            S_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CNT_BLK: begin
                o_cmd.cnt_block = 1'b1;
                if (i_sts.rl_last) n_state = S_CNT_TRM;
            end
            S_CNT_TRM: begin
                o_cmd.cnt_term = 1'b1;
                if (i_sts.pl_last) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_CNT_BLK;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_DEC_INIT;
            end
            S_DEC_INIT: begin
                o_cmd.dec_init = 1'b1;
                n_state = S_DEC_BLK;
            end
            S_DEC_BLK: begin
                if (i_sts.s_lt_block) begin
                    o_cmd.dig_init_sub = 1'b1;
                    n_state = S_DIG;
                end else begin
                    o_cmd.dec_block = 1'b1;
                    if (i_sts.rl_last) n_state = S_DEC_TRM;
                end
            end
            S_DEC_TRM: begin
                if (i_sts.s_lt_pats) begin
                    o_cmd.dig_init_term = 1'b1;
                    n_state = S_DIG;
                end else begin
                    o_cmd.dec_term = 1'b1;
                    n_state = S_DEC_BLK;
                end
            end
            S_DIG: begin
                if (i_sts.dig_none) n_state = S_EMIT;
                else                o_cmd.dig_step = 1'b1;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ok = 1'b1;
                    if (i_sts.slot_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

### hdl/rrsu_dp.sv
// Datapath of the rule-set unranker: config, shape count, divider, digit unit, output.
`default_nettype none
`include "assert_macros.svh"
module rrsu_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rrsu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rrsu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [rrsu_pkg::RANK_W-1:0]         i_rank,
    input  wire rrsu_pkg::t_cmd                      i_cmd,
    output rrsu_pkg::t_status                        o_sts,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [rrsu_pkg::SLOT_W-1:0]              o_slot,
    output logic [rrsu_pkg::SHAPE_W-1:0]             o_shape_number,
    output logic [rrsu_pkg::LEN_W-1:0]               o_pattern_length,
    output logic [rrsu_pkg::LEN_W-1:0]               o_replacement_length,
    output logic                                     o_is_terminal,
    output logic [rrsu_pkg::WORD_W-1:0]              o_pattern_word,
    output logic [rrsu_pkg::WORD_W-1:0]              o_replacement_word,
    output logic                                     o_status,
    output logic                                     o_last
);
    import rrsu_pkg::*;

    logic [ALPHA_W-1:0]   r_alpha;
    logic [RULES_W-1:0]   r_rules;
    logic [LEN_W-1:0]     r_maxp, r_maxr;

    logic [RANK_W-1:0]    r_rank;
    logic [SHAPE_W-1:0]   r_total, r_prem, r_block, r_s, r_shape;
    logic [PATS_W-1:0]    r_pats;
    logic [LEN_W-1:0]     r_pl, r_rl;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_term;

    logic [DIG_Q_W-1:0]   r_q;
    logic [ALPHA_W-1:0]   r_drem;
    logic [DSUB_W-1:0]    r_dsub;
    logic [DCNT_W-1:0]    r_k, r_dleft;
    logic [WORD_W-1:0]    r_pword, r_rword;
    logic [LEN_W-1:0]     r_lbits;

    logic                 r_ovalid;
    logic [SLOT_W-1:0]    r_oslot;
    logic [SHAPE_W-1:0]   r_oshape;
    logic [LEN_W-1:0]     r_opl, r_orl;
    logic                 r_oterm, r_ostatus, r_olast;
    logic [WORD_W-1:0]    r_opword, r_orword;

    logic [SHAPE_W+ALPHA_W-1:0] block_x;
    logic [PATS_W+ALPHA_W-1:0]  pats_x;
    logic [SHAPE_W:0]           trial, diff;
    logic                       geq;
    logic [DIG_Q_W-1:0]         step_q;
    logic [ALPHA_W-1:0]         step_rem;
    logic                       dig_done;
    logic [DCNT_W-1:0]          fidx;
    logic                       to_rep;
    logic [DCNT_W-1:0]          shamt;
    logic [WORD_W-1:0]          placed;
    logic                       bad;

    assign block_x = r_block * r_alpha;
    assign pats_x  = r_pats * r_alpha;

    // One bit of restoring division of the rank by the shape count per cycle.
    assign trial = {r_prem, r_rank[RANK_W-1]};
    assign diff  = trial - {1'b0, r_total};
    assign geq   = (trial >= {1'b0, r_total});

    // Eight bits of division by the alphabet size per cycle; remainder stays narrow.
    always_comb begin
        logic [ALPHA_W:0]   t;
        logic [ALPHA_W-1:0] rem;
        logic [DIG_Q_W-1:0] q;
        rem = r_drem;
        q   = r_q;
        for (int i = 0; i < DIG_BITS; i++) begin
            t = {rem, q[DIG_Q_W-1]};
            q = {q[DIG_Q_W-2:0], 1'b0};
            if (t >= {1'b0, r_alpha}) begin
                t    = t - {1'b0, r_alpha};
                q[0] = 1'b1;
            end
            rem = t[ALPHA_W-1:0];
        end
        step_q   = q;
        step_rem = rem;
    end

    assign dig_done = (r_dsub == DSUB_W'(DIG_STEPS - 1));
    assign to_rep   = (r_k < {1'b0, r_rl});
    assign fidx     = to_rep ? r_k : (r_k - {1'b0, r_rl});
    assign shamt    = DCNT_W'({2'b0, fidx[1:0]} * {1'b0, r_lbits});
    assign placed   = WORD_W'({{(WORD_W-DIGIT_W){1'b0}}, step_rem[DIGIT_W-1:0]} << shamt);

    assign bad = (r_alpha < 5'd2) || (r_alpha > ALPHA_W'(MAX_LETTERS))
              || (r_rules == '0) || (r_rules > RULES_W'(MAX_RULES))
              || (r_maxp > LEN_W'(MAX_STR_LEN)) || (r_maxr > LEN_W'(MAX_STR_LEN))
              || (r_maxp == '0);

    always_comb begin
        o_sts.bad        = bad;
        o_sts.rl_last    = (r_rl == r_maxr);
        o_sts.pl_last    = (r_pl == r_maxp);
        o_sts.div_last   = (r_dcnt == '1);
        o_sts.s_lt_block = (r_s < r_block);
        o_sts.s_lt_pats  = (r_s < {{(SHAPE_W-PATS_W){1'b0}}, r_pats});
        o_sts.dig_none   = (r_dleft == '0);
        o_sts.slot_last  = (({1'b0, r_slot} + 5'd1) == r_rules);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 5'd2;
            r_rules <= 5'd1;
            r_maxp  <= 3'd1;
            r_maxr  <= 3'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHABET: r_alpha <= i_cfg_data;
                CFG_RULES:    r_rules <= i_cfg_data;
                CFG_MAX_PAT:  r_maxp  <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_REP:  r_maxr  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_dleft <= '0;
            r_dcnt  <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_rank  <= i_rank;
                r_total <= '0;
                r_slot  <= '0;
                r_lbits <= letter_bits(r_alpha);
            end
            if (i_cmd.load_item || i_cmd.dec_init) begin
                r_pl    <= 3'd1;
                r_rl    <= '0;
                r_pats  <= PATS_W'(r_alpha);
                r_block <= SHAPE_W'(r_alpha);
            end
            if (i_cmd.cnt_block || i_cmd.dec_block) begin
                r_rl    <= r_rl + 3'd1;
                r_block <= block_x[SHAPE_W-1:0];
            end
            if (i_cmd.cnt_term || i_cmd.dec_term) begin
                r_pl    <= r_pl + 3'd1;
                r_rl    <= '0;
                r_pats  <= pats_x[PATS_W-1:0];
                r_block <= SHAPE_W'(pats_x);
            end
            if (i_cmd.cnt_block) r_total <= r_total + r_block;
            if (i_cmd.cnt_term)  r_total <= r_total + SHAPE_W'(r_pats);
            if (i_cmd.dec_block) r_s <= r_s - r_block;
            if (i_cmd.dec_term)  r_s <= r_s - SHAPE_W'(r_pats);
            if (i_cmd.div_init) begin
                r_prem <= '0;
                r_dcnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_prem <= geq ? diff[SHAPE_W-1:0] : trial[SHAPE_W-1:0];
                r_rank <= {r_rank[RANK_W-2:0], geq};
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.dec_init) begin
                r_s     <= r_prem;
                r_shape <= r_prem;
            end
            if (i_cmd.dig_init_sub || i_cmd.dig_init_term) begin
                r_q     <= DIG_Q_W'(r_s);
                r_drem  <= '0;
                r_dsub  <= '0;
                r_k     <= '0;
                r_pword <= '0;
                r_rword <= '0;
                r_term  <= i_cmd.dig_init_term;
                r_dleft <= i_cmd.dig_init_term ? DCNT_W'(r_pl)
                                               : DCNT_W'(r_pl) + DCNT_W'(r_rl);
            end
            // A terminal rule has no replacement letters.
            if (i_cmd.dig_init_term) r_rl <= '0;
            if (i_cmd.dig_step) begin
                r_q <= step_q;
                if (dig_done) begin
                    r_drem  <= '0;
                    r_dsub  <= '0;
                    r_k     <= r_k + 1'b1;
                    r_dleft <= r_dleft - 1'b1;
                    if (to_rep) r_rword <= r_rword | placed;
                    else        r_pword <= r_pword | placed;
                end else begin
                    r_drem <= step_rem;
                    r_dsub <= r_dsub + 1'b1;
                end
            end
            if (i_cmd.emit_ok) r_slot <= r_slot + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_ok || i_cmd.emit_err) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit_ok) begin
            r_oslot   <= r_slot;
            r_oshape  <= r_shape;
            r_opl     <= r_pl;
            r_orl     <= r_rl;
            r_oterm   <= r_term;
            r_opword  <= r_pword;
            r_orword  <= r_rword;
            r_ostatus <= 1'b0;
            r_olast   <= o_sts.slot_last;
        end else if (i_cmd.emit_err) begin
            r_oslot   <= '0;
            r_oshape  <= '0;
            r_opl     <= '0;
            r_orl     <= '0;
            r_oterm   <= 1'b0;
            r_opword  <= '0;
            r_orword  <= '0;
            r_ostatus <= 1'b1;
            r_olast   <= 1'b1;
        end
    end

    assign o_out_valid          = r_ovalid;
    assign o_slot               = r_oslot;
    assign o_shape_number       = r_oshape;
    assign o_pattern_length     = r_opl;
    assign o_replacement_length = r_orl;
    assign o_is_terminal        = r_oterm;
    assign o_pattern_word       = r_opword;
    assign o_replacement_word   = r_orword;
    assign o_status             = r_ostatus;
    assign o_last               = r_olast;

    `ASSERT_IMPL(a_err_is_last, i_clk, i_rst_n, r_ovalid && r_ostatus, r_olast)
    `ASSERT_IMPL(a_rem_below_total, i_clk, i_rst_n, i_cmd.dec_init, r_prem < r_total)
    `ASSERT_NEXT(a_ok_has_pattern, i_clk, i_rst_n, i_cmd.emit_ok, r_opl != '0)
endmodule
`default_nettype wire

### hdl/rewrite_rule_set_unranker.sv
// Top level of the rule-set unranker: sequencer plus datapath.
//
// Usage: an input item carries a 64-bit rank on i_rank (valid/ready). For each
// rank the block emits one result item per rule slot (rules_in_set items, slot 0
// first, o_last on the final one) on the output valid/ready channel. A bad
// configuration gives a single item with o_status and o_last set.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
// Steps: the shape count walks every (pattern, replacement) length pair and
// every pattern length. Each slot then passes through the bit-serial rank
// divider, a setup step, the decode steps, the digit unit letter by letter
// (up to 8 letters), and the emit step.
// One item is worked on at a time; o_in_ready is high only while the block is
// idle. Results go through an output register, so work on the next slot goes
// on while a result waits; a stalled receiver holds the sequencer only when
// the next result is ready to be written.
// Reset (synchronous, active low) restores the configuration defaults and
// drops any item in progress and any pending result.
`default_nettype none
module rewrite_rule_set_unranker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rrsu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rrsu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [rrsu_pkg::RANK_W-1:0]     i_rank,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [rrsu_pkg::SLOT_W-1:0]          o_slot,
    output logic [rrsu_pkg::SHAPE_W-1:0]         o_shape_number,
    output logic [rrsu_pkg::LEN_W-1:0]           o_pattern_length,
    output logic [rrsu_pkg::LEN_W-1:0]           o_replacement_length,
    output logic                                 o_is_terminal,
    output logic [rrsu_pkg::WORD_W-1:0]          o_pattern_word,
    output logic [rrsu_pkg::WORD_W-1:0]          o_replacement_word,
    output logic                                 o_status,
    output logic                                 o_last
);
    import rrsu_pkg::*;

    t_cmd    cmd;
    t_status sts;

    rrsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrsu_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_rank               (i_rank),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_slot               (o_slot),
        .o_shape_number       (o_shape_number),
        .o_pattern_length     (o_pattern_length),
        .o_replacement_length (o_replacement_length),
        .o_is_terminal        (o_is_terminal),
        .o_pattern_word       (o_pattern_word),
        .o_replacement_word   (o_replacement_word),
        .o_status             (o_status),
        .o_last               (o_last)
    );
endmodule
`default_nettype wire

### bench/rewrite_rule_set_unranker_test.sv
// Self-checking bench for the rule-set unranker: predicts each decoded rule and compares.
`timescale 1ns / 1ps
`default_nettype none
module rewrite_rule_set_unranker_test;
    import rrsu_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [SHAPE_W-1:0] shape;
        logic [LEN_W-1:0]   plen;
        logic [LEN_W-1:0]   rlen;
        logic               term;
        logic [WORD_W-1:0]  pword;
        logic [WORD_W-1:0]  rword;
        logic               status;
        logic               last;
    } t_rule;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_ALPHABET;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [RANK_W-1:0]     i_rank = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SLOT_W-1:0]     o_slot;
    logic [SHAPE_W-1:0]    o_shape_number;
    logic [LEN_W-1:0]      o_pattern_length;
    logic [LEN_W-1:0]      o_replacement_length;
    logic                  o_is_terminal;
    logic [WORD_W-1:0]     o_pattern_word;
    logic [WORD_W-1:0]     o_replacement_word;
    logic                  o_status;
    logic                  o_last;

    rewrite_rule_set_unranker dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [4:0] alpha_q = 5'd2;
    logic [4:0] rules_q = 5'd1;
    logic [2:0] maxpat_q = 3'd1;
    logic [2:0] maxrep_q = 3'd0;

    t_rule pending_rules[$];
    int    error_count = 0;
    int    hold_cycles = 0;
    bit    receiver_random = 1'b1;

    function automatic logic [63:0] ipow(logic [63:0] b, int e);
        logic [63:0] r;
        r = 1;
        for (int k = 0; k < e; k++) r = r * b;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pack_word(logic [63:0] v, int len, int bits);
        logic [63:0] w;
        w = 0;
        for (int k = 0; k < len; k++) begin
            w = w | ((v % alpha_q) << (k * bits));
            v = v / alpha_q;
        end
        return w[WORD_W-1:0];
    endfunction

    task automatic predict_rules(logic [RANK_W-1:0] rank);
        logic [63:0] total, pats, reps, blk, s, rem;
        int    bits;
        bit    bad, found;
        t_rule r;
        bad = (alpha_q < 2) || (alpha_q > MAX_LETTERS) || (rules_q == 0) ||
              (rules_q > MAX_RULES) || (maxpat_q > MAX_STR_LEN) || (maxrep_q > MAX_STR_LEN);
        total = 0;
        if (!bad) begin
            for (int pl = 1; pl <= maxpat_q; pl++) begin
                pats = ipow(alpha_q, pl);
                for (int rl = 0; rl <= maxrep_q; rl++) total += pats * ipow(alpha_q, rl);
                total += pats;
            end
            total = total & 64'h1_FFFF_FFFF;
        end
        if (bad || total == 0) begin
            r = '0;
            r.status = 1'b1;
            r.last = 1'b1;
            pending_rules.push_back(r);
            return;
        end
        bits = 0;
        while ((1 << bits) < alpha_q) bits++;
        rem = rank;
        for (int sl = 0; sl < rules_q; sl++) begin
            s = rem % total;
            rem = rem / total;
            r = '0;
            r.slot = sl[SLOT_W-1:0];
            r.shape = s[SHAPE_W-1:0];
            r.last = (sl + 1 == rules_q);
            found = 1'b0;
            for (int pl = 1; pl <= maxpat_q && !found; pl++) begin
                pats = ipow(alpha_q, pl);
                for (int rl = 0; rl <= maxrep_q && !found; rl++) begin
                    reps = ipow(alpha_q, rl);
                    blk = pats * reps;
                    if (s < blk) begin
                        found = 1'b1;
                        r.plen = pl[LEN_W-1:0];
                        r.rlen = rl[LEN_W-1:0];
                        r.pword = pack_word(s / reps, pl, bits);
                        r.rword = pack_word(s % reps, rl, bits);
                    end else begin
                        s -= blk;
                    end
                end
                if (!found) begin
                    if (s < pats) begin
                        found = 1'b1;
                        r.plen = pl[LEN_W-1:0];
                        r.term = 1'b1;
                        r.pword = pack_word(s, pl, bits);
                    end else begin
                        s -= pats;
                    end
                end
            end
            pending_rules.push_back(r);
        end
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Result checker and receiver-side stalls.
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_rule got, want;
            got = '{o_slot, o_shape_number, o_pattern_length, o_replacement_length,
                    o_is_terminal, o_pattern_word, o_replacement_word, o_status, o_last};
            if (pending_rules.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = pending_rules.pop_front();
                if (got.slot !== want.slot) report_mismatch("slot");
                if (got.shape !== want.shape) report_mismatch("shape_number");
                if (got.plen !== want.plen) report_mismatch("pattern_length");
                if (got.rlen !== want.rlen) report_mismatch("replacement_length");
                if (got.term !== want.term) report_mismatch("is_terminal");
                if (got.pword !== want.pword) report_mismatch("pattern_word");
                if (got.rword !== want.rword) report_mismatch("replacement_word");
                if (got.status !== want.status) report_mismatch("status");
                if (got.last !== want.last) report_mismatch("last");
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (!receiver_random) begin
            i_out_ready <= 1'b1;
        end else if (o_out_valid && i_out_ready) begin
            out_gap = $urandom_range(0, 5);
            i_out_ready <= (out_gap == 0);
        end else if (out_gap > 0) begin
            out_gap = out_gap - 1;
            i_out_ready <= (out_gap == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Valid stays high after an item is taken; a gap or a drain drops it.
    task automatic send_rank(logic [RANK_W-1:0] rank, bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            if (i_in_valid) i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rank <= rank;
        predict_rules(rank);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results;
        if (i_in_valid) i_in_valid <= 1'b0;
        while (pending_rules.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_ALPHABET: alpha_q = value;
            CFG_RULES:    rules_q = value;
            CFG_MAX_PAT:  maxpat_q = value[2:0];
            CFG_MAX_REP:  maxrep_q = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [4:0] a, logic [4:0] r, logic [4:0] p, logic [4:0] q);
        drain_results();
        write_reg(CFG_ALPHABET, a);
        write_reg(CFG_RULES, r);
        write_reg(CFG_MAX_PAT, p);
        write_reg(CFG_MAX_REP, q);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_reset_defaults;
        send_rank('0);
        send_rank('1);
        send_rank(64'd1);
    endtask

    task automatic test_directed_extremes;
        set_config(5'd16, 5'd16, 5'd4, 5'd4);
        send_rank('1);
        send_rank('0);
        send_rank(64'h8000_0000_0000_0000);
        set_config(5'd2, 5'd16, 5'd4, 5'd0);
        send_rank('1);
        send_rank(64'h5555_5555_5555_5555);
        set_config(5'd3, 5'd4, 5'd2, 5'd2);
        for (int k = 0; k < 6; k++) send_rank(64'(k * 7));
        send_rank(64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_bad_configs;
        set_config(5'd0, 5'd1, 5'd1, 5'd0);  send_rank(rand64());
        set_config(5'd1, 5'd1, 5'd1, 5'd0);  send_rank(rand64());
        set_config(5'd17, 5'd1, 5'd1, 5'd0); send_rank(rand64());
        set_config(5'd31, 5'd1, 5'd1, 5'd0); send_rank(rand64());
        set_config(5'd4, 5'd0, 5'd1, 5'd0);  send_rank(rand64());
        set_config(5'd4, 5'd17, 5'd1, 5'd0); send_rank(rand64());
        set_config(5'd4, 5'd31, 5'd1, 5'd0); send_rank(rand64());
        set_config(5'd4, 5'd2, 5'd5, 5'd0);  send_rank(rand64());
        set_config(5'd4, 5'd2, 5'd7, 5'd0);  send_rank(rand64());
        set_config(5'd4, 5'd2, 5'd1, 5'd7);  send_rank(rand64());
        set_config(5'd4, 5'd2, 5'd0, 5'd2);  send_rank(rand64());
    endtask

    // Mostly valid settings with small slot counts; bad ones now and then.
    task automatic test_random_ranks;
        for (int phase = 0; phase < 30; phase++) begin
            if ($urandom_range(0, 9) == 0)
                set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                           5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)));
            else
                set_config(5'($urandom_range(2, 16)),
                           5'($urandom_range(0, 3) == 0 ? $urandom_range(1, 16)
                                                        : $urandom_range(1, 4)),
                           5'($urandom_range(1, 4)), 5'($urandom_range(0, 4)));
            for (int k = 0; k < 10; k++) send_rank(rand64());
        end
    endtask

    // Receiver holds off while ranks keep coming, then the sender waits for all results; then an always-ready one.
    task automatic test_backpressure;
        set_config(5'd2, 5'd3, 5'd1, 5'd1);
        hold_cycles = 3000;
        for (int k = 0; k < 8; k++) send_rank(rand64(), 1'b0);
        drain_results();
        receiver_random = 1'b0;
        for (int k = 0; k < 10; k++) send_rank(rand64(), 1'b0);
        drain_results();
        receiver_random = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_extremes();
        test_bad_configs();
        test_backpressure();
        test_random_ranks();
        drain_results();
        if (error_count == 0)
            $display("rewrite_rule_set_unranker_test passed");
        else
            $display("rewrite_rule_set_unranker_test failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("rewrite_rule_set_unranker_test failed");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/rrsu_pkg.sv
hdl/rrsu_ctrl.sv
hdl/rrsu_dp.sv
hdl/rewrite_rule_set_unranker.sv
bench/rewrite_rule_set_unranker_test.sv
